FILE: sv/t4i_pkg.sv
package t4i_pkg;

  localparam int unsigned PalDepth  = 16;
  localparam int unsigned PalWidth  = 16;
  localparam int unsigned PalAddrW  = $clog2(PalDepth);
  localparam int unsigned IconBytes = 512;
  localparam int unsigned PosW      = $clog2(IconBytes);
  localparam int unsigned CoordW    = 5;
  localparam int unsigned ChanW     = 8;

  localparam logic [PosW-1:0]  LastPos     = PosW'(IconBytes - 1);
  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;
  localparam logic [ChanW-1:0] AlphaClear  = 8'h00;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_ICON    = 1'b1
  } cmd_e;

  // one icon byte waiting to be split into its two pixels
  typedef struct packed {
    logic [3:0]          x_pair;   // {tileX, pX}: column / 2
    logic [CoordW-1:0]   row;
    logic [PalAddrW-1:0] idx_lo;
    logic [PalAddrW-1:0] idx_hi;
    logic                done;
  } byte_info_t;

endpackage

FILE: sv/t4i_ram.sv
module t4i_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: sv/t4i_byte_stage.sv
module t4i_byte_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [3:0]                     palette_slot_i,
  input  logic [15:0]                    palette_word_i,
  input  logic [7:0]                     icon_byte_i,
  input  logic                           icon_start_i,
  input  logic                           pop_i,
  output logic                           byte_valid_o,
  output t4i_pkg::byte_info_t            byte_info_o,
  output logic [t4i_pkg::PalWidth-1:0]   word_lo_o,
  output logic [t4i_pkg::PalWidth-1:0]   word_hi_o
);
  import t4i_pkg::*;

  logic                byte_valid_q, byte_valid_d;
  byte_info_t          info_q, info_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PosW-1:0]     pos_cur;
  logic                accept, take_byte, take_pal;

  assign in_ready_o = !byte_valid_q || pop_i;
  assign accept     = in_valid_i && in_ready_o;
  assign take_byte  = accept && (cmd_e'(command_i) == CMD_ICON);
  assign take_pal   = accept && (cmd_e'(command_i) == CMD_PALETTE);

  assign pos_cur = icon_start_i ? '0 : pos_q;

  always_comb begin
    pos_d        = pos_q;
    byte_valid_d = byte_valid_q;
    info_d       = info_q;
    if (pop_i) begin
      byte_valid_d = 1'b0;
    end
    if (take_byte) begin
      pos_d         = pos_cur + 1'b1;  // wraps at the end of the icon
      byte_valid_d  = 1'b1;
      info_d.x_pair = {pos_cur[6:5], pos_cur[1:0]};
      info_d.row    = {pos_cur[8:7], pos_cur[4:2]};
      info_d.idx_lo = icon_byte_i[3:0];
      info_d.idx_hi = icon_byte_i[7:4];
      info_d.done   = (pos_cur == LastPos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      byte_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      byte_valid_q <= byte_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    info_q <= info_d;
  end

  // palette read lines up with the byte register; a write one word earlier is seen
  t4i_ram #(
    .Width (PalWidth),
    .Depth (PalDepth)
  ) u_palette (
    .clk_i     (clk_i),
    .we_i      (take_pal),
    .waddr_i   (palette_slot_i),
    .wdata_i   (palette_word_i),
    .re_i      (take_byte),
    .raddr_a_i (icon_byte_i[3:0]),
    .raddr_b_i (icon_byte_i[7:4]),
    .rdata_a_o (word_lo_o),
    .rdata_b_o (word_hi_o)
  );

  assign byte_valid_o = byte_valid_q;
  assign byte_info_o  = info_q;

endmodule

FILE: sv/t4i_pixel_out.sv
module t4i_pixel_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           byte_valid_i,
  input  t4i_pkg::byte_info_t            byte_info_i,
  input  logic [t4i_pkg::PalWidth-1:0]   word_lo_i,
  input  logic [t4i_pkg::PalWidth-1:0]   word_hi_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [t4i_pkg::CoordW-1:0]     pixel_x_o,
  output logic [t4i_pkg::CoordW-1:0]     pixel_y_o,
  output logic [t4i_pkg::ChanW-1:0]      red_o,
  output logic [t4i_pkg::ChanW-1:0]      green_o,
  output logic [t4i_pkg::ChanW-1:0]      blue_o,
  output logic [t4i_pkg::ChanW-1:0]      alpha_o,
  output logic                           pair_last_o,
  output logic                           icon_done_o
);
  import t4i_pkg::*;

  logic                out_valid_q, out_valid_d;
  logic                half_q, half_d;      // 1: low pixel already sent
  logic                load;
  logic [PalWidth-1:0] word;
  logic [PalAddrW-1:0] idx;
  logic [CoordW-1:0]   x_q, x_d, y_q, y_d;
  logic [ChanW-1:0]    r_q, r_d, g_q, g_d, b_q, b_d, a_q, a_d;
  logic                last_q, last_d, done_q, done_d;

  assign load  = byte_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && half_q;

  assign word = half_q ? word_hi_i : word_lo_i;
  assign idx  = half_q ? byte_info_i.idx_hi : byte_info_i.idx_lo;

  always_comb begin
    out_valid_d = out_valid_q;
    half_d      = half_q;
    x_d = x_q; y_d = y_q; r_d = r_q; g_d = g_q; b_d = b_q; a_d = a_q;
    last_d = last_q; done_d = done_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      half_d      = !half_q;
      x_d    = {byte_info_i.x_pair, half_q};
      y_d    = byte_info_i.row;
      r_d    = {word[4:0], 3'b000};
      g_d    = {word[9:5], 3'b000};
      b_d    = {word[14:10], 3'b000};
      a_d    = (idx == '0 && word == '0) ? AlphaClear : AlphaOpaque;
      last_d = half_q;
      done_d = half_q && byte_info_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      half_q      <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    r_q    <= r_d;
    g_q    <= g_d;
    b_q    <= b_d;
    a_q    <= a_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = x_q;
  assign pixel_y_o   = y_q;
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;
  assign alpha_o     = a_q;
  assign pair_last_o = last_q;
  assign icon_done_o = done_q;

endmodule

FILE: sv/tiled_4bpp_icon_to_rgba_top.sv
// Tiled 4bpp icon decoder. Each input word either writes one of 16 RGB15
// palette entries (command 0, no output) or carries one icon byte (command 1)
// that yields two RGBA pixels, low nibble first, each tagged with its x/y in
// the 32x32 icon; icon_start restarts the byte count at zero. A palette write
// is seen by the next byte. A byte goes to the byte register, then one pixel
// at a time to the single output register; the byte register frees as the
// high pixel loads. Palette writes go one per cycle while it is free. The
// palette must be written before any entry it uses is read.
module tiled_4bpp_icon_to_rgba_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [3:0]                  palette_slot_i,
  input  logic [15:0]                 palette_word_i,
  input  logic [7:0]                  icon_byte_i,
  input  logic                        icon_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [t4i_pkg::CoordW-1:0]  pixel_x_o,
  output logic [t4i_pkg::CoordW-1:0]  pixel_y_o,
  output logic [t4i_pkg::ChanW-1:0]   red_o,
  output logic [t4i_pkg::ChanW-1:0]   green_o,
  output logic [t4i_pkg::ChanW-1:0]   blue_o,
  output logic [t4i_pkg::ChanW-1:0]   alpha_o,
  output logic                        pair_last_o,
  output logic                        icon_done_o
);
  import t4i_pkg::*;

  logic                byte_valid, pop;
  byte_info_t          byte_info;
  logic [PalWidth-1:0] word_lo, word_hi;

  t4i_byte_stage u_byte_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .palette_slot_i (palette_slot_i),
    .palette_word_i (palette_word_i),
    .icon_byte_i    (icon_byte_i),
    .icon_start_i   (icon_start_i),
    .pop_i          (pop),
    .byte_valid_o   (byte_valid),
    .byte_info_o    (byte_info),
    .word_lo_o      (word_lo),
    .word_hi_o      (word_hi)
  );

  t4i_pixel_out u_pixel_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_info_i  (byte_info),
    .word_lo_i    (word_lo),
    .word_hi_i    (word_hi),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .pair_last_o  (pair_last_o),
    .icon_done_o  (icon_done_o)
  );

endmodule

FILE: verif/tb_tiled_4bpp_icon_to_rgba_top.sv
`timescale 1ns / 100ps

module tb_tiled_4bpp_icon_to_rgba_top;
  import t4i_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int MixedWords = 300;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ChanW-1:0]  r;
    logic [ChanW-1:0]  g;
    logic [ChanW-1:0]  b;
    logic [ChanW-1:0]  a;
    logic              last;
    logic              done;
  } pixel_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  slot;
    logic [15:0] word;
    logic [7:0]  icon_b;
    logic        start;
  } word_t;

  typedef struct packed {
    word_t  w;
    bit     chk;
    pixel_t lo;
    pixel_t hi;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [3:0] palette_slot = '0;
  logic [15:0] palette_word = '0;
  logic [7:0] icon_byte = '0;
  logic icon_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CoordW-1:0] pixel_x, pixel_y;
  logic [ChanW-1:0] red, green, blue, alpha;
  logic pair_last, icon_done;

  // predictor state
  logic [15:0] palette_shadow [PalDepth];
  logic [PosW-1:0] byte_pos = '0;
  pixel_t expected_pixels [$];

  int err_cnt = 0;
  int cyc = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  int rdy_mode = 0;
  logic [7:0] rdy_mask = 8'hFF;
  logic [4:0] rdy_tick = '0;

  tiled_4bpp_icon_to_rgba_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .palette_slot_i (palette_slot),
    .palette_word_i (palette_word),
    .icon_byte_i    (icon_byte),
    .icon_start_i   (icon_start),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .alpha_o        (alpha),
    .pair_last_o    (pair_last),
    .icon_done_o    (icon_done)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_v);
    if (got != exp_v) report($sformatf("%s got %0d expected %0d", name, got, exp_v));
  endtask

  function automatic pixel_t px(input int x, input int y, input int r, input int g,
                                input int b, input int a, input int last, input int done);
    pixel_t p;
    p.x = CoordW'(x);
    p.y = CoordW'(y);
    p.r = ChanW'(r);
    p.g = ChanW'(g);
    p.b = ChanW'(b);
    p.a = ChanW'(a);
    p.last = 1'(last);
    p.done = 1'(done);
    return p;
  endfunction

  function automatic pixel_t shade_pixel(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                         input logic [3:0] idx, input logic last,
                                         input logic done);
    logic [15:0] w;
    pixel_t p;
    w = palette_shadow[idx];
    p.x = x;
    p.y = y;
    p.r = {w[4:0], 3'b000};
    p.g = {w[9:5], 3'b000};
    p.b = {w[14:10], 3'b000};
    p.a = (idx == 4'd0 && w == 16'h0000) ? AlphaClear : AlphaOpaque;
    p.last = last;
    p.done = done;
    return p;
  endfunction

  // updates the shadow state; queues typed pixels if given, else predicted ones
  task automatic decode_icon_word(input word_t w, input bit typed, input pixel_t t_lo,
                                  input pixel_t t_hi);
    logic [PosW-1:0] p;
    logic [CoordW-1:0] col, row;
    pixel_t lo, hi;
    if (w.cmd == CMD_PALETTE) begin
      palette_shadow[w.slot] = w.word;
    end else begin
      if (w.start) byte_pos = '0;
      p = byte_pos;
      col = {p[6:5], p[1:0], 1'b0};
      row = {p[8:7], p[4:2]};
      lo = shade_pixel(col, row, w.icon_b[3:0], 1'b0, 1'b0);
      hi = shade_pixel(col | 5'd1, row, w.icon_b[7:4], 1'b1, p == LastPos);
      byte_pos = p + 1'b1;
      expected_pixels.push_back(typed ? t_lo : lo);
      expected_pixels.push_back(typed ? t_hi : hi);
    end
  endtask

  function automatic dir_row_t pal_row(input logic [3:0] s, input logic [15:0] w);
    dir_row_t d;
    d = '0;
    d.w.cmd = CMD_PALETTE;
    d.w.slot = s;
    d.w.word = w;
    d.w.icon_b = 8'($urandom);
    d.w.start = 1'($urandom);
    return d;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] b, input logic st, input bit chk,
                                        input pixel_t lo, input pixel_t hi);
    dir_row_t d;
    d.w.cmd = CMD_ICON;
    d.w.slot = 4'($urandom);
    d.w.word = 16'($urandom);
    d.w.icon_b = b;
    d.w.start = st;
    d.chk = chk;
    d.lo = lo;
    d.hi = hi;
    return d;
  endfunction

  function automatic word_t rand_word(input int pal_pct, input int start_pct);
    word_t w;
    w.cmd = ($urandom_range(99) < pal_pct) ? CMD_PALETTE : CMD_ICON;
    w.slot = 4'($urandom);
    w.word = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
    w.icon_b = 8'($urandom);
    w.start = ($urandom_range(99) < start_pct);
    return w;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input word_t w, input bit chk, input pixel_t lo, input pixel_t hi);
    if (!steady && burst_left == 0) begin
      int gap;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    command <= w.cmd;
    palette_slot <= w.slot;
    palette_word <= w.word;
    icon_byte <= w.icon_b;
    icon_start <= w.start;
    do @(posedge clk_i); while (!in_ready);
    decode_icon_word(w, chk, lo, hi);
    @(negedge clk_i);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // receiver stall pattern, reshuffled each time rdy_tick wraps
  always @(negedge clk_i) begin
    if (rdy_tick == 0) begin
      rdy_mode = $urandom_range(3);
      rdy_mask = 8'($urandom) | 8'h01;
    end
    rdy_tick <= rdy_tick + 1'b1;
    case (rdy_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      2: out_ready <= rdy_mask[rdy_tick[2:0]];
      default: out_ready <= ($urandom_range(3) == 0);
    endcase
  end

  always @(posedge clk_i) begin : pixel_check
    pixel_t exp_p;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected pixel x %0d y %0d", pixel_x, pixel_y));
      end else begin
        exp_p = expected_pixels.pop_front();
        check_field("pixel_x", int'(pixel_x), int'(exp_p.x));
        check_field("pixel_y", int'(pixel_y), int'(exp_p.y));
        check_field("red", int'(red), int'(exp_p.r));
        check_field("green", int'(green), int'(exp_p.g));
        check_field("blue", int'(blue), int'(exp_p.b));
        check_field("alpha", int'(alpha), int'(exp_p.a));
        check_field("pair_last", int'(pair_last), int'(exp_p.last));
        check_field("icon_done", int'(icon_done), int'(exp_p.done));
      end
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    word_t w;
    int n_bytes;
    pixel_t none;
    none = '0;

    // palette extremes: clear black, all ones, black at a nonzero index,
    // bit 15 alone, pure channels
    dir_tab.push_back(pal_row(4'd0, 16'h0000));
    dir_tab.push_back(pal_row(4'd15, 16'hFFFF));
    dir_tab.push_back(pal_row(4'd1, 16'h0000));
    dir_tab.push_back(pal_row(4'd2, 16'h8000));
    dir_tab.push_back(pal_row(4'd3, 16'h001F));
    dir_tab.push_back(pal_row(4'd4, 16'h03E0));
    dir_tab.push_back(pal_row(4'd5, 16'h7C00));
    dir_tab.push_back(pal_row(4'd6, 16'h1234));
    dir_tab.push_back(pal_row(4'd7, 16'h5678));
    dir_tab.push_back(pal_row(4'd8, 16'h7FFF));
    dir_tab.push_back(pal_row(4'd9, 16'h4210));
    dir_tab.push_back(pal_row(4'd10, 16'h2108));
    dir_tab.push_back(pal_row(4'd11, 16'h0421));
    dir_tab.push_back(pal_row(4'd12, 16'hABCD));
    dir_tab.push_back(pal_row(4'd13, 16'h5555));
    dir_tab.push_back(pal_row(4'd14, 16'hAAAA));
    dir_tab.push_back(byte_row(8'hF0, 1'b1, 1'b1, px(0, 0, 0, 0, 0, 0, 0, 0),
                               px(1, 0, 248, 248, 248, 255, 1, 0)));
    dir_tab.push_back(byte_row(8'h21, 1'b0, 1'b1, px(2, 0, 0, 0, 0, 255, 0, 0),
                               px(3, 0, 0, 0, 0, 255, 1, 0)));
    dir_tab.push_back(byte_row(8'h43, 1'b0, 1'b1, px(4, 0, 248, 0, 0, 255, 0, 0),
                               px(5, 0, 0, 248, 0, 255, 1, 0)));
    // palette write mid-icon is seen by the next word
    dir_tab.push_back(pal_row(4'd0, 16'h8000));
    dir_tab.push_back(byte_row(8'h05, 1'b0, 1'b1, px(6, 0, 0, 0, 248, 255, 0, 0),
                               px(7, 0, 0, 0, 0, 255, 1, 0)));
    dir_tab.push_back(pal_row(4'd0, 16'h0000));
    // restart mid-icon
    dir_tab.push_back(byte_row(8'hFF, 1'b1, 1'b1, px(0, 0, 248, 248, 248, 255, 0, 0),
                               px(1, 0, 248, 248, 248, 255, 1, 0)));
    dir_tab.push_back(byte_row(8'h00, 1'b0, 1'b1, px(2, 0, 0, 0, 0, 0, 0, 0),
                               px(3, 0, 0, 0, 0, 0, 1, 0)));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].chk, dir_tab[i].lo, dir_tab[i].hi);

    // one whole icon from a fresh start, a few palette words mixed in;
    // the first stretch goes without sender gaps
    n_bytes = 0;
    steady = 1'b1;
    while (n_bytes < IconBytes) begin
      if (n_bytes == 128) steady = 1'b0;
      w = rand_word(4, 0);
      if (w.cmd == CMD_ICON) begin
        w.start = (n_bytes == 0);
        n_bytes++;
      end
      send_word(w, 1'b0, none, none);
    end

    // hold off until the block has emptied
    drain_pixels();
    @(negedge clk_i);

    // mixed traffic, continues past the wrap
    repeat (MixedWords) begin
      w = rand_word(25, 3);
      send_word(w, 1'b0, none, none);
    end

    drain_pixels();
    if (expected_pixels.size() != 0) report("pixels left over");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
